// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define FTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define FTS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/fts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fts_pkg;

  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int REM_W      = 31;
  localparam int QUO_W      = 22;
  localparam int CNT_W      = 5;
  localparam int ACC_W      = 22;

  localparam logic [CNT_W-1:0] ITER_FRAC = 5'd16;
  localparam logic [CNT_W-1:0] ITER_ACC  = 5'd22;

  localparam logic [19:0] RST_FIXED_STEP = 20'd16667;
  localparam logic [19:0] RST_MAX_DELTA  = 20'd100000;
  localparam logic [7:0]  RST_NORMAL     = 8'd2;
  localparam logic [7:0]  RST_CPU_BUDGET = 8'd1;
  localparam logic [15:0] RST_ENTER      = 16'd14746;
  localparam logic [15:0] RST_EXIT       = 16'd11469;
  localparam logic [7:0]  RST_RECOVERY   = 8'd3;

  typedef enum logic [1:0] {
    FUNC_ADVANCE = 2'd0,
    FUNC_RESET   = 2'd1,
    FUNC_SUSPEND = 2'd2,
    FUNC_RESUME  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIXED_STEP    = 3'd0,
    REG_MAX_DELTA     = 3'd1,
    REG_NORMAL_BUDGET = 3'd2,
    REG_CPU_BUDGET    = 3'd3,
    REG_ENTER_RATIO   = 3'd4,
    REG_EXIT_RATIO    = 3'd5,
    REG_RECOVERY      = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_RATIO = 2'd0,
    DIV_ACC   = 2'd1,
    DIV_ALPHA = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RATIO,
    S_RATIO_W,
    S_MODE,
    S_ACC,
    S_ACC_W,
    S_STEPS,
    S_ALPHA,
    S_ALPHA_W,
    S_DONE
  } state_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] raw_frame_delta_us;
    logic               raw_delta_invalid;
    logic signed [31:0] prev_cpu_us;
    logic               prev_cpu_invalid;
    logic               fixed_step_enabled;
  } in_t;

  typedef struct packed {
    logic [19:0] frame_delta_us;
    logic [30:0] clamp_loss_us;
    logic [7:0]  step_count;
    logic [21:0] dropped_steps;
    logic [15:0] alpha;
    logic        cpu_bound;
    logic        suspended_flag;
  } out_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_sel_t div_sel;
    logic     upd_mode;
    logic     upd_steps;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic full_path;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: design/fts_div.sv
`timescale 1ns / 1ps
`default_nettype none
module fts_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [fts_pkg::REM_W-1:0]   rem_init,
  input  wire logic [fts_pkg::QUO_W-1:0]   shin_init,
  input  wire logic [fts_pkg::REM_W-1:0]   divisor,
  input  wire logic [fts_pkg::CNT_W-1:0]   iters,
  output logic                             busy,
  output logic [fts_pkg::QUO_W-1:0]        quo,
  output logic [fts_pkg::REM_W-1:0]        rem
);

  logic                        busy_r;
  logic [fts_pkg::CNT_W-1:0]   cnt_r;
  logic [fts_pkg::REM_W-1:0]   rem_r;
  logic [fts_pkg::REM_W-1:0]   div_r;
  logic [fts_pkg::QUO_W-1:0]   shin_r;
  logic [fts_pkg::QUO_W-1:0]   quo_r;
  logic [fts_pkg::REM_W:0]     trial;
  logic                        ge;

  // restoring step: one quotient bit per cycle, msb first
  assign trial = {rem_r, shin_r[fts_pkg::QUO_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == fts_pkg::CNT_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= iters;
      rem_r  <= rem_init;
      div_r  <= divisor;
      shin_r <= shin_init;
      quo_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - fts_pkg::CNT_W'(1);
      rem_r  <= ge ? fts_pkg::REM_W'(trial - {1'b0, div_r}) : trial[fts_pkg::REM_W-1:0];
      shin_r <= {shin_r[fts_pkg::QUO_W-2:0], 1'b0};
      quo_r  <= {quo_r[fts_pkg::QUO_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: design/fts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module fts_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fts_pkg::cmd_t                 cmd,
  output fts_pkg::stat_t                     stat,
  input  wire fts_pkg::in_t                  in_data,
  output fts_pkg::out_t                      out_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  input  wire logic                          cfg_valid,
  input  wire logic [fts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fts_pkg::CFG_W-1:0]     cfg_data
);

  logic [19:0] fs_r, max_r;
  logic [7:0]  normal_r, cpub_r, recov_r;
  logic [15:0] enter_r, exit_r;

  fts_pkg::in_t  in_r;
  fts_pkg::out_t out_r, out_nxt;
  logic          out_valid_r;

  logic [fts_pkg::ACC_W-1:0] acc_r;
  logic [7:0]                hc_r;
  logic                      mode_r, susp_r;
  logic [7:0]                count_r;
  logic [21:0]               drop_r;

  logic [19:0] fs_eff, delta;
  logic        raw_valid, raw_over;
  logic [30:0] raw_mag, loss, ref_v, cpu_v;
  logic        ratio_sat, ge_enter, le_exit;
  logic [15:0] exit_eff;
  logic [7:0]  hc_inc, cpu_budget, budget;
  logic [fts_pkg::ACC_W-1:0] acc_sum;

  logic                          div_busy;
  logic [fts_pkg::QUO_W-1:0]     div_quo;
  logic [fts_pkg::REM_W-1:0]     div_rem, d_rem_init, d_divisor;
  logic [fts_pkg::QUO_W-1:0]     d_shin;
  logic [fts_pkg::CNT_W-1:0]     d_iters;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r     <= fts_pkg::RST_FIXED_STEP;
      max_r    <= fts_pkg::RST_MAX_DELTA;
      normal_r <= fts_pkg::RST_NORMAL;
      cpub_r   <= fts_pkg::RST_CPU_BUDGET;
      enter_r  <= fts_pkg::RST_ENTER;
      exit_r   <= fts_pkg::RST_EXIT;
      recov_r  <= fts_pkg::RST_RECOVERY;
    end else if (cfg_valid) begin
      unique case (fts_pkg::cfg_reg_t'(cfg_index))
        fts_pkg::REG_FIXED_STEP:    fs_r     <= cfg_data[19:0];
        fts_pkg::REG_MAX_DELTA:     max_r    <= cfg_data[19:0];
        fts_pkg::REG_NORMAL_BUDGET: normal_r <= cfg_data[7:0];
        fts_pkg::REG_CPU_BUDGET:    cpub_r   <= cfg_data[7:0];
        fts_pkg::REG_ENTER_RATIO:   enter_r  <= cfg_data[15:0];
        fts_pkg::REG_EXIT_RATIO:    exit_r   <= cfg_data[15:0];
        fts_pkg::REG_RECOVERY:      recov_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // frame delta, clamp loss, ratio reference, mode compares, budget and accumulator sum
  always_comb begin
    fs_eff    = (fs_r == 20'd0) ? 20'd1 : fs_r;
    raw_valid = !in_r.raw_delta_invalid && !in_r.raw_frame_delta_us[31];
    raw_mag   = in_r.raw_frame_delta_us[30:0];
    raw_over  = raw_mag > {11'd0, max_r};
    if (!raw_valid) begin
      delta = fs_eff;
    end else if (raw_over) begin
      delta = max_r;
    end else begin
      delta = raw_mag[19:0];
    end
    loss = (raw_valid && raw_over) ? raw_mag - {11'd0, max_r} : 31'd0;
    if (raw_valid && raw_mag > {11'd0, fs_eff}) begin
      ref_v = raw_mag;
    end else begin
      ref_v = {11'd0, fs_eff};
    end
    cpu_v = (in_r.prev_cpu_invalid || in_r.prev_cpu_us[31]) ? 31'd0 : in_r.prev_cpu_us[30:0];
    ratio_sat  = {2'b00, cpu_v} >= {ref_v, 2'b00};
    exit_eff   = (exit_r < enter_r) ? exit_r : enter_r;
    ge_enter   = ratio_sat || (div_quo[15:0] >= enter_r);
    le_exit    = !ratio_sat && (div_quo[15:0] <= exit_eff);
    hc_inc     = (hc_r == 8'd255) ? hc_r : hc_r + 8'd1;
    cpu_budget = (cpub_r < normal_r) ? cpub_r : normal_r;
    budget     = mode_r ? cpu_budget : normal_r;
    acc_sum    = acc_r + {2'b00, delta};
  end

  always_comb begin
    case (cmd.div_sel)
      fts_pkg::DIV_RATIO: begin
        // cpu < 4*ref keeps the quotient of (cpu << 14) / ref within 16 bits
        d_rem_init = {2'b00, cpu_v[30:2]};
        d_shin     = {cpu_v[1:0], 20'd0};
        d_divisor  = ref_v;
        d_iters    = fts_pkg::ITER_FRAC;
      end
      fts_pkg::DIV_ACC: begin
        d_rem_init = '0;
        d_shin     = acc_sum;
        d_divisor  = {11'd0, fs_eff};
        d_iters    = fts_pkg::ITER_ACC;
      end
      default: begin
        d_rem_init = {9'd0, acc_r};
        d_shin     = '0;
        d_divisor  = {11'd0, fs_eff};
        d_iters    = fts_pkg::ITER_FRAC;
      end
    endcase
  end

  fts_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .rem_init  (d_rem_init),
    .shin_init (d_shin),
    .divisor   (d_divisor),
    .iters     (d_iters),
    .busy      (div_busy),
    .quo       (div_quo),
    .rem       (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.upd_steps) begin
      if (div_quo < {14'd0, budget}) begin
        count_r <= div_quo[7:0];
        drop_r  <= '0;
      end else begin
        count_r <= budget;
        drop_r  <= div_quo - {14'd0, budget};
      end
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    out_nxt = '0;
    if (in_r.func != fts_pkg::FUNC_ADVANCE) begin
      if (in_r.func == fts_pkg::FUNC_SUSPEND) begin
        out_nxt.suspended_flag = 1'b1;
      end else if (in_r.func == fts_pkg::FUNC_RESUME) begin
        out_nxt.suspended_flag = 1'b0;
      end else begin
        out_nxt.suspended_flag = susp_r;
      end
    end else if (susp_r) begin
      out_nxt.suspended_flag = 1'b1;
    end else begin
      out_nxt.frame_delta_us = delta;
      out_nxt.clamp_loss_us  = loss;
      if (in_r.fixed_step_enabled) begin
        out_nxt.step_count    = count_r;
        out_nxt.dropped_steps = drop_r;
        out_nxt.alpha         = div_quo[15:0];
        out_nxt.cpu_bound     = mode_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      hc_r        <= '0;
      mode_r      <= 1'b0;
      susp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd_mode) begin
        if (ge_enter) begin
          mode_r <= 1'b1;
          hc_r   <= '0;
        end else if (mode_r) begin
          if (le_exit) begin
            if (hc_inc >= recov_r) begin
              mode_r <= 1'b0;
              hc_r   <= '0;
            end else begin
              hc_r <= hc_inc;
            end
          end else begin
            hc_r <= '0;
          end
        end
      end
      // whatever the budget, only the part below one step stays
      if (cmd.upd_steps) begin
        acc_r <= div_rem[fts_pkg::ACC_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        if (in_r.func != fts_pkg::FUNC_ADVANCE) begin
          acc_r  <= '0;
          hc_r   <= '0;
          mode_r <= 1'b0;
          if (in_r.func == fts_pkg::FUNC_SUSPEND) begin
            susp_r <= 1'b1;
          end else if (in_r.func == fts_pkg::FUNC_RESUME) begin
            susp_r <= 1'b0;
          end
        end else if (!susp_r && !in_r.fixed_step_enabled) begin
          acc_r  <= '0;
          hc_r   <= '0;
          mode_r <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.full_path = (in_r.func == fts_pkg::FUNC_ADVANCE) && !susp_r &&
                          in_r.fixed_step_enabled;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_data       = out_r;
  assign out_valid      = out_valid_r;

endmodule
`default_nettype wire

// File: design/fts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fts_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fts_pkg::stat_t stat,
  output fts_pkg::cmd_t       cmd
);

  fts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = fts_pkg::DIV_RATIO;
    in_ready    = 1'b0;
    unique case (state_r)
      fts_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = fts_pkg::S_DECODE;
        end
      end
      fts_pkg::S_DECODE: begin
        state_nxt = stat.full_path ? fts_pkg::S_RATIO : fts_pkg::S_DONE;
      end
      fts_pkg::S_RATIO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = fts_pkg::DIV_RATIO;
        state_nxt     = fts_pkg::S_RATIO_W;
      end
      fts_pkg::S_RATIO_W: begin
        if (!stat.div_busy) begin
          state_nxt = fts_pkg::S_MODE;
        end
      end
      fts_pkg::S_MODE: begin
        cmd.upd_mode = 1'b1;
        state_nxt    = fts_pkg::S_ACC;
      end
      fts_pkg::S_ACC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = fts_pkg::DIV_ACC;
        state_nxt     = fts_pkg::S_ACC_W;
      end
      fts_pkg::S_ACC_W: begin
        if (!stat.div_busy) begin
          state_nxt = fts_pkg::S_STEPS;
        end
      end
      fts_pkg::S_STEPS: begin
        cmd.upd_steps = 1'b1;
        state_nxt     = fts_pkg::S_ALPHA;
      end
      fts_pkg::S_ALPHA: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = fts_pkg::DIV_ALPHA;
        state_nxt     = fts_pkg::S_ALPHA_W;
      end
      fts_pkg::S_ALPHA_W: begin
        if (!stat.div_busy) begin
          state_nxt = fts_pkg::S_DONE;
        end
      end
      fts_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = fts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fts_pkg::S_IDLE;
      end
    endcase
  end

  `FTS_ASSERT(a_start_idle, cmd.div_start |-> !stat.div_busy, "divider started while busy")
  `FTS_ASSERT(a_start_busy, cmd.div_start |=> stat.div_busy, "divider did not go busy")
  `FTS_ASSERT(a_load_free, cmd.out_load |-> stat.out_free, "result overwrote pending transfer")
  `FTS_NEVER(a_capture_busy, cmd.capture && stat.div_busy, "item taken while divider busy")

endmodule
`default_nettype wire

// File: design/fixed_timestep_frame_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | ports                          | transfer when
// in       | in_valid, in_ready, in_data    | in_valid && in_ready
// out      | out_valid, out_ready, out_data | out_valid && out_ready
// cfg      | cfg_valid, cfg_ready, cfg_*    | cfg_valid && cfg_ready (always ready)
// advance with steps enabled: three passes of the shared radix-2 divider
// (16 + 22 + 16 iterations) between the sequencing states; other items go from
// decode straight to the output stage.
// one item in flight; the next is taken while its result waits in the output register.
// reset is synchronous active low and restores config and control, not data registers.
// a stalled output holds the finished item until the transfer.
module fixed_timestep_frame_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fts_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fts_pkg::out_t                      out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fts_pkg::CFG_W-1:0]     cfg_data
);

  fts_pkg::cmd_t  cmd;
  fts_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  fts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fts_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire
